>>> rtl/otc_pkg.sv
package otc_pkg;

	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned TARGET_BITS   = 32;
	localparam int unsigned EVT_BITS      = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_LC_TARGET     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LC_CODE_START = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_IF_TARGET     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HF_TRIM_START = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RC_TRIM_START = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_IF_TRIM_START = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_EVENT_TOTAL   = 3'd6;

	// fixed register widths as seen on the configuration port
	localparam int unsigned LC_START_BITS = 16;
	localparam int unsigned HF_START_BITS = 10;
	localparam int unsigned RC_START_BITS = 15;
	localparam int unsigned IF_START_BITS = 10;

	// window count thresholds
	localparam logic [31:0] HF_SLOW        = 32'd1997000;
	localparam logic [31:0] HF_FAST        = 32'd2003000;
	localparam logic [31:0] RC_FAST_COARSE = 32'd200600;
	localparam logic [31:0] RC_FAST_FINE   = 32'd200080;
	localparam logic [31:0] RC_FAST_SUPER  = 32'd200015;
	localparam logic [31:0] RC_SLOW_COARSE = 32'd199400;
	localparam logic [31:0] RC_SLOW_FINE   = 32'd199920;
	localparam logic [31:0] RC_SLOW_SUPER  = 32'd199985;
	localparam logic [31:0] IF_BAND        = 32'd1400;

	localparam int unsigned HF_BORROW_FINE = 10;
	localparam int unsigned HF_CARRY_FINE  = 23;
	localparam int unsigned IF_CARRY_DROP  = 8;

	localparam logic [TARGET_BITS-1:0] IF_TARGET_RESET   = 32'd1400;
	localparam logic [EVT_BITS-1:0]    EVENT_TOTAL_RESET = 8'd10;
	localparam logic [EVT_BITS-1:0]    WARMUP_EVENTS     = 8'd2;

	typedef struct packed {
		logic apply;
		logic done;
	} otc_step_t;

endpackage

>>> rtl/otc_seq.sv
module otc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [otc_pkg::EVT_BITS-1:0]  event_total,
	output otc_pkg::otc_step_t            status
);
	import otc_pkg::*;

	logic [EVT_BITS-1:0] event_index_q;
	logic                finished_q;
	logic [EVT_BITS-1:0] index_inc;
	logic                last_event;

	assign index_inc  = event_index_q + EVT_BITS'(1);
	assign last_event = !finished_q && (index_inc == event_total);

	// outcome of the event currently at the head of the pipe
	assign status.apply = !finished_q && (index_inc > WARMUP_EVENTS);
	assign status.done  = finished_q || last_event;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_index_q <= '0;
			finished_q    <= 1'b0;
		end else if (step && !finished_q) begin
			if (last_event) begin
				event_index_q <= '0;
				finished_q    <= 1'b1;
			end else begin
				event_index_q <= index_inc;
			end
		end
	end

endmodule

>>> rtl/otc_correct.sv
module otc_correct #(
	parameter int unsigned TRIM_BITS    = 5,
	parameter int unsigned LC_CODE_BITS = 16,
	parameter int unsigned COUNT_BITS   = 32
) (
	input  logic [2*TRIM_BITS-1:0]               hf_trim,
	input  logic [3*TRIM_BITS-1:0]               rc_trim,
	input  logic [LC_CODE_BITS-1:0]              lc_tune,
	input  logic [2*TRIM_BITS-1:0]               if_trim,
	input  logic [COUNT_BITS-1:0]                hf_count,
	input  logic [COUNT_BITS-1:0]                rc_count,
	input  logic [COUNT_BITS-1:0]                lc_count,
	input  logic [COUNT_BITS-1:0]                if_count,
	input  logic [otc_pkg::TARGET_BITS-1:0]      lc_goal,
	input  logic [otc_pkg::TARGET_BITS-1:0]      if_target,
	output logic [2*TRIM_BITS-1:0]               hf_trim_nxt,
	output logic [3*TRIM_BITS-1:0]               rc_trim_nxt,
	output logic [LC_CODE_BITS-1:0]              lc_tune_nxt,
	output logic [2*TRIM_BITS-1:0]               if_trim_nxt
);
	import otc_pkg::*;

	localparam int unsigned FINE_MAX_I = (1 << TRIM_BITS) - 1;
	localparam logic [TRIM_BITS-1:0] FINE_MAX = TRIM_BITS'(FINE_MAX_I);
	localparam logic [TRIM_BITS-1:0] HF_BORROW_SET =
		TRIM_BITS'((HF_BORROW_FINE < FINE_MAX_I) ? HF_BORROW_FINE : FINE_MAX_I);
	localparam logic [TRIM_BITS-1:0] HF_CARRY_SET =
		TRIM_BITS'((HF_CARRY_FINE < FINE_MAX_I) ? HF_CARRY_FINE : FINE_MAX_I);
	localparam logic [TRIM_BITS-1:0] IF_CARRY_SET =
		TRIM_BITS'((1 << TRIM_BITS) - IF_CARRY_DROP);
	localparam logic [LC_CODE_BITS-1:0] LC_MAX = '1;

	logic [31:0] hf_w, rc_w, lc_w, if_w;
	logic [32:0] if_hi;

	assign hf_w  = 32'(hf_count);
	assign rc_w  = 32'(rc_count);
	assign lc_w  = 32'(lc_count);
	assign if_w  = 32'(if_count);
	// upper deadband edge without wrap
	assign if_hi = {1'b0, if_target} + {1'b0, IF_BAND};

	// hf: fine with borrow from and carry into coarse
	always_comb begin
		logic [TRIM_BITS-1:0] c;
		logic [TRIM_BITS-1:0] f;
		c = hf_trim[2*TRIM_BITS-1:TRIM_BITS];
		f = hf_trim[TRIM_BITS-1:0];
		if (hf_w < HF_SLOW) begin
			if (f != '0) begin
				f = f - TRIM_BITS'(1);
			end else if (c != '0) begin
				c = c - TRIM_BITS'(1);
				f = HF_BORROW_SET;
			end
		end else if (hf_w > HF_FAST) begin
			if (f != FINE_MAX) begin
				f = f + TRIM_BITS'(1);
			end else if (c != FINE_MAX) begin
				c = c + TRIM_BITS'(1);
				f = HF_CARRY_SET;
			end
		end
		hf_trim_nxt = {c, f};
	end

	always_comb begin
		lc_tune_nxt = lc_tune;
		if (lc_w > lc_goal && lc_tune != '0) begin
			lc_tune_nxt = lc_tune - LC_CODE_BITS'(1);
		end else if (lc_w < lc_goal && lc_tune != LC_MAX) begin
			lc_tune_nxt = lc_tune + LC_CODE_BITS'(1);
		end
	end

	// rc: step size picked by how far the count is off
	always_comb begin
		logic [TRIM_BITS-1:0] c;
		logic [TRIM_BITS-1:0] f;
		logic [TRIM_BITS-1:0] s;
		c = rc_trim[3*TRIM_BITS-1:2*TRIM_BITS];
		f = rc_trim[2*TRIM_BITS-1:TRIM_BITS];
		s = rc_trim[TRIM_BITS-1:0];
		if (rc_w > RC_FAST_COARSE) begin
			if (c != FINE_MAX) c = c + TRIM_BITS'(1);
		end else if (rc_w > RC_FAST_FINE) begin
			if (f != FINE_MAX) f = f + TRIM_BITS'(1);
		end else if (rc_w > RC_FAST_SUPER) begin
			if (s != FINE_MAX) s = s + TRIM_BITS'(1);
		end
		if (rc_w < RC_SLOW_COARSE) begin
			if (c != '0) c = c - TRIM_BITS'(1);
		end else if (rc_w < RC_SLOW_FINE) begin
			if (f != '0) f = f - TRIM_BITS'(1);
		end else if (rc_w < RC_SLOW_SUPER) begin
			if (s != '0) s = s - TRIM_BITS'(1);
		end
		rc_trim_nxt = {c, f, s};
	end

	// if: fine with carry into coarse, slow test off when target is under the band
	always_comb begin
		logic [TRIM_BITS-1:0] c;
		logic [TRIM_BITS-1:0] f;
		c = if_trim[2*TRIM_BITS-1:TRIM_BITS];
		f = if_trim[TRIM_BITS-1:0];
		if ({1'b0, if_w} > if_hi) begin
			if (f != FINE_MAX) begin
				f = f + TRIM_BITS'(1);
			end else if (c != FINE_MAX) begin
				f = IF_CARRY_SET;
				c = c + TRIM_BITS'(1);
			end
		end
		if (if_target >= IF_BAND && if_w < (if_target - IF_BAND)) begin
			if (f != '0) f = f - TRIM_BITS'(1);
		end
		if_trim_nxt = {c, f};
	end

endmodule

>>> rtl/oscillator_trim_calibrator.sv
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// in       | in_valid / in_stall        | hf_count, rc_count, lc_count, if_count
// out      | out_valid / out_stall      | trim codes, lc_code, apply, done_res
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data (ready is always high)
//
// one event per cycle sustained while out_stall is low: the counts sit in an input
// register, the correction is one compare/increment level, and the result lands in the
// output register; out_valid rises as an event moves into it from the input register.
// arst_n clears the event counter, done flag and pipe valids; trims return to zero.
// in_stall rises only when both the input stage and the output register are full
// and out_stall is high.
module oscillator_trim_calibrator #(
	parameter int unsigned TRIM_BITS    = 5,
	parameter int unsigned LC_CODE_BITS = 16,
	parameter int unsigned COUNT_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [COUNT_BITS-1:0]                hf_count,
	input  logic [COUNT_BITS-1:0]                rc_count,
	input  logic [COUNT_BITS-1:0]                lc_count,
	input  logic [COUNT_BITS-1:0]                if_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [TRIM_BITS-1:0]                 hf_coarse,
	output logic [TRIM_BITS-1:0]                 hf_fine,
	output logic [TRIM_BITS-1:0]                 rc_coarse,
	output logic [TRIM_BITS-1:0]                 rc_fine,
	output logic [TRIM_BITS-1:0]                 rc_superfine,
	output logic [LC_CODE_BITS-1:0]              lc_code,
	output logic [TRIM_BITS-1:0]                 ifclk_coarse,
	output logic [TRIM_BITS-1:0]                 if_fine,
	output logic                                 apply,
	output logic                                 done_res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [otc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [otc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import otc_pkg::*;

	logic [TARGET_BITS-1:0]    lc_goal_q;
	logic [TARGET_BITS-1:0]    if_target_q;
	logic [EVT_BITS-1:0]       event_total_q;

	logic [2*TRIM_BITS-1:0]    hf_trim_q, hf_trim_nxt;
	logic [3*TRIM_BITS-1:0]    rc_trim_q, rc_trim_nxt;
	logic [LC_CODE_BITS-1:0]   lc_tune_q, lc_tune_nxt;
	logic [2*TRIM_BITS-1:0]    if_trim_q, if_trim_nxt;

	logic                      valid_s1;
	logic [COUNT_BITS-1:0]     hf_count_s1, rc_count_s1, lc_count_s1, if_count_s1;

	logic                      out_valid_q;
	logic [2*TRIM_BITS-1:0]    hf_out_q;
	logic [3*TRIM_BITS-1:0]    rc_out_q;
	logic [LC_CODE_BITS-1:0]   lc_out_q;
	logic [2*TRIM_BITS-1:0]    if_out_q;
	logic                      apply_q;
	logic                      done_q;

	logic                      in_xfer;
	logic                      advance;
	logic                      cfg_wr;
	otc_step_t                 step_st;

	logic [2*TRIM_BITS-1:0]    hf_res;
	logic [3*TRIM_BITS-1:0]    rc_res;
	logic [LC_CODE_BITS-1:0]   lc_res;
	logic [2*TRIM_BITS-1:0]    if_res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign in_xfer   = in_valid && !in_stall;

	otc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.event_total (event_total_q),
		.status      (step_st)
	);

	otc_correct #(
		.TRIM_BITS    (TRIM_BITS),
		.LC_CODE_BITS (LC_CODE_BITS),
		.COUNT_BITS   (COUNT_BITS)
	) u_correct (
		.hf_trim     (hf_trim_q),
		.rc_trim     (rc_trim_q),
		.lc_tune     (lc_tune_q),
		.if_trim     (if_trim_q),
		.hf_count    (hf_count_s1),
		.rc_count    (rc_count_s1),
		.lc_count    (lc_count_s1),
		.if_count    (if_count_s1),
		.lc_goal     (lc_goal_q),
		.if_target   (if_target_q),
		.hf_trim_nxt (hf_trim_nxt),
		.rc_trim_nxt (rc_trim_nxt),
		.lc_tune_nxt (lc_tune_nxt),
		.if_trim_nxt (if_trim_nxt)
	);

	// codes after this event; unchanged during warm-up and after done
	assign hf_res = step_st.apply ? hf_trim_nxt : hf_trim_q;
	assign rc_res = step_st.apply ? rc_trim_nxt : rc_trim_q;
	assign lc_res = step_st.apply ? lc_tune_nxt : lc_tune_q;
	assign if_res = step_st.apply ? if_trim_nxt : if_trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_goal_q     <= '0;
			if_target_q   <= IF_TARGET_RESET;
			event_total_q <= EVENT_TOTAL_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_LC_TARGET:   lc_goal_q     <= TARGET_BITS'(cfg_data);
				REG_IF_TARGET:   if_target_q   <= TARGET_BITS'(cfg_data);
				REG_EVENT_TOTAL: event_total_q <= EVT_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// trim state: a start-register write loads the trim directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hf_trim_q <= '0;
			rc_trim_q <= '0;
			lc_tune_q <= '0;
			if_trim_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_LC_CODE_START:
					lc_tune_q <= LC_CODE_BITS'(cfg_data[LC_START_BITS-1:0]);
				REG_HF_TRIM_START:
					hf_trim_q <= (2*TRIM_BITS)'(cfg_data[HF_START_BITS-1:0]);
				REG_RC_TRIM_START:
					rc_trim_q <= (3*TRIM_BITS)'(cfg_data[RC_START_BITS-1:0]);
				REG_IF_TRIM_START:
					if_trim_q <= (2*TRIM_BITS)'(cfg_data[IF_START_BITS-1:0]);
				default: ;
			endcase
		end else if (advance) begin
			hf_trim_q <= hf_res;
			rc_trim_q <= rc_res;
			lc_tune_q <= lc_res;
			if_trim_q <= if_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hf_count_s1 <= hf_count;
			rc_count_s1 <= rc_count;
			lc_count_s1 <= lc_count;
			if_count_s1 <= if_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hf_out_q <= hf_res;
			rc_out_q <= rc_res;
			lc_out_q <= lc_res;
			if_out_q <= if_res;
			apply_q  <= step_st.apply;
			done_q   <= step_st.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign hf_coarse    = hf_out_q[2*TRIM_BITS-1:TRIM_BITS];
	assign hf_fine      = hf_out_q[TRIM_BITS-1:0];
	assign rc_coarse    = rc_out_q[3*TRIM_BITS-1:2*TRIM_BITS];
	assign rc_fine      = rc_out_q[2*TRIM_BITS-1:TRIM_BITS];
	assign rc_superfine = rc_out_q[TRIM_BITS-1:0];
	assign lc_code      = lc_out_q;
	assign ifclk_coarse = if_out_q[2*TRIM_BITS-1:TRIM_BITS];
	assign if_fine      = if_out_q[TRIM_BITS-1:0];
	assign apply        = apply_q;
	assign done_res     = done_q;

endmodule

>>> sim/oscillator_trim_calibrator_test.sv
`timescale 1ns / 1ps

module oscillator_trim_calibrator_test;
	import otc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PRINT_CAP = 30;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [4:0] CODE_MAX = 5'd31;
	localparam logic [15:0] LC_MAX = 16'hFFFF;
	localparam logic [31:0] IF_TARGET_MAX = 32'd4294965895;
	localparam logic [31:0] HF_NOMINAL = 32'd2000000;
	localparam logic [31:0] RC_NOMINAL = 32'd200000;
	localparam longint COUNT_TOP = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] hf;
		logic [31:0] rc;
		logic [31:0] lc;
		logic [31:0] if_cnt;
	} counts_t;

	typedef struct packed {
		logic [4:0]  hf_coarse;
		logic [4:0]  hf_fine;
		logic [4:0]  rc_coarse;
		logic [4:0]  rc_fine;
		logic [4:0]  rc_superfine;
		logic [15:0] lc_code;
		logic [4:0]  ifclk_coarse;
		logic [4:0]  if_fine;
		logic        apply;
		logic        done;
	} trims_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	logic [31:0] hf_count, rc_count, lc_count, if_count;
	logic out_valid, out_stall;
	logic [4:0] hf_coarse, hf_fine, rc_coarse, rc_fine, rc_superfine, ifclk_coarse, if_fine;
	logic [15:0] lc_code;
	logic apply, done_res;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// calibrator state as the testbench sees it
	logic [31:0] lc_goal_r = 32'd0;
	logic [31:0] if_target_r = IF_TARGET_RESET;
	logic [7:0]  event_total_r = EVENT_TOTAL_RESET;
	logic [7:0]  evt_index = 8'd0;
	logic        cal_done = 1'b0;
	logic [9:0]  hf_trim = 10'd0;
	logic [14:0] rc_trim = 15'd0;
	logic [15:0] lc_tune = 16'd0;
	logic [9:0]  if_trim = 10'd0;

	trims_t pending_trims[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_hold = 0;

	oscillator_trim_calibrator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hf_count(hf_count),
		.rc_count(rc_count),
		.lc_count(lc_count),
		.if_count(if_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hf_coarse(hf_coarse),
		.hf_fine(hf_fine),
		.rc_coarse(rc_coarse),
		.rc_fine(rc_fine),
		.rc_superfine(rc_superfine),
		.lc_code(lc_code),
		.ifclk_coarse(ifclk_coarse),
		.if_fine(if_fine),
		.apply(apply),
		.done_res(done_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stall: mostly short bursts, a few long ones
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 30);
		end else begin
			out_stall <= 1'b0;
			stall_hold = $urandom_range(0, 3);
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch in result %0d, %s: got %0h, expected %0h",
				results_seen, field, got, want);
	endtask

	always @(posedge clk) begin : check_results
		trims_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_trims.size() == 0) begin
				report_mismatch("unexpected transfer", 32'd1, 32'd0);
			end else begin
				want = pending_trims.pop_front();
				if (hf_coarse !== want.hf_coarse)
					report_mismatch("hf_coarse", 32'(hf_coarse), 32'(want.hf_coarse));
				if (hf_fine !== want.hf_fine)
					report_mismatch("hf_fine", 32'(hf_fine), 32'(want.hf_fine));
				if (rc_coarse !== want.rc_coarse)
					report_mismatch("rc_coarse", 32'(rc_coarse), 32'(want.rc_coarse));
				if (rc_fine !== want.rc_fine)
					report_mismatch("rc_fine", 32'(rc_fine), 32'(want.rc_fine));
				if (rc_superfine !== want.rc_superfine)
					report_mismatch("rc_superfine", 32'(rc_superfine),
						32'(want.rc_superfine));
				if (lc_code !== want.lc_code)
					report_mismatch("lc_code", 32'(lc_code), 32'(want.lc_code));
				if (ifclk_coarse !== want.ifclk_coarse)
					report_mismatch("ifclk_coarse", 32'(ifclk_coarse),
						32'(want.ifclk_coarse));
				if (if_fine !== want.if_fine)
					report_mismatch("if_fine", 32'(if_fine), 32'(want.if_fine));
				if (apply !== want.apply)
					report_mismatch("apply", 32'(apply), 32'(want.apply));
				if (done_res !== want.done)
					report_mismatch("done_res", 32'(done_res), 32'(want.done));
			end
		end
	end

	// one correction step on every trim
	task automatic nudge_trims(input counts_t c);
		logic [4:0] co, fi, sf;
		{co, fi} = hf_trim;
		if (c.hf < HF_SLOW) begin
			if (fi != 5'd0) begin
				fi--;
			end else if (co != 5'd0) begin
				co--;
				fi = 5'(HF_BORROW_FINE);
			end
		end else if (c.hf > HF_FAST) begin
			if (fi != CODE_MAX) begin
				fi++;
			end else if (co != CODE_MAX) begin
				co++;
				fi = 5'(HF_CARRY_FINE);
			end
		end
		hf_trim = {co, fi};

		if (c.lc > lc_goal_r && lc_tune != 16'd0)
			lc_tune--;
		if (c.lc < lc_goal_r && lc_tune != LC_MAX)
			lc_tune++;

		{co, fi, sf} = rc_trim;
		if (c.rc > RC_FAST_COARSE) begin
			if (co != CODE_MAX) co++;
		end else if (c.rc > RC_FAST_FINE) begin
			if (fi != CODE_MAX) fi++;
		end else if (c.rc > RC_FAST_SUPER) begin
			if (sf != CODE_MAX) sf++;
		end
		if (c.rc < RC_SLOW_COARSE) begin
			if (co != 5'd0) co--;
		end else if (c.rc < RC_SLOW_FINE) begin
			if (fi != 5'd0) fi--;
		end else if (c.rc < RC_SLOW_SUPER) begin
			if (sf != 5'd0) sf--;
		end
		rc_trim = {co, fi, sf};

		// upper deadband edge in 33 bits so it cannot wrap
		{co, fi} = if_trim;
		if ({1'b0, c.if_cnt} > {1'b0, if_target_r} + {1'b0, IF_BAND}) begin
			if (fi != CODE_MAX) begin
				fi++;
			end else if (co != CODE_MAX) begin
				fi = 5'(32 - IF_CARRY_DROP);
				co++;
			end
		end
		if (if_target_r >= IF_BAND && c.if_cnt < if_target_r - IF_BAND) begin
			if (fi != 5'd0) fi--;
		end
		if_trim = {co, fi};
	endtask

	task automatic predict_trims(input counts_t c, output trims_t r);
		r.apply = 1'b0;
		if (!cal_done) begin
			evt_index++;
			if (evt_index > WARMUP_EVENTS) begin
				nudge_trims(c);
				r.apply = 1'b1;
			end
			if (evt_index == event_total_r) begin
				evt_index = 8'd0;
				cal_done = 1'b1;
			end
		end
		{r.hf_coarse, r.hf_fine} = hf_trim;
		{r.rc_coarse, r.rc_fine, r.rc_superfine} = rc_trim;
		r.lc_code = lc_tune;
		{r.ifclk_coarse, r.if_fine} = if_trim;
		r.done = cal_done;
	endtask

	function automatic int unsigned pick_gap(input int unsigned pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// called right after a rising edge; returns after transfer and idle gap
	task automatic send_counts(input counts_t c);
		trims_t r;
		int unsigned gap;
		in_valid <= 1'b1;
		hf_count <= c.hf;
		rc_count <= c.rc;
		lc_count <= c.lc;
		if_count <= c.if_cnt;
		do @(posedge clk); while (in_stall);
		predict_trims(c, r);
		pending_trims.push_back(r);
		gap = pick_gap(idle_pct);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data,
		input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LC_TARGET: lc_goal_r = data;
			REG_LC_CODE_START: lc_tune = data[15:0];
			REG_IF_TARGET: if_target_r = data;
			REG_HF_TRIM_START: hf_trim = data[9:0];
			REG_RC_TRIM_START: rc_trim = data[14:0];
			REG_IF_TRIM_START: if_trim = data[9:0];
			REG_EVENT_TOTAL: event_total_r = data[7:0];
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic load_trim_plan(input logic [31:0] hf_start, input logic [31:0] rc_start,
		input logic [31:0] if_start, input logic [31:0] lc_start,
		input logic [31:0] lc_tgt, input logic [31:0] if_tgt);
		write_reg(REG_HF_TRIM_START, hf_start, 1'b0);
		write_reg(REG_RC_TRIM_START, rc_start, 1'b0);
		write_reg(REG_IF_TRIM_START, if_start, 1'b0);
		write_reg(REG_LC_CODE_START, lc_start, 1'b0);
		write_reg(REG_LC_TARGET, lc_tgt, 1'b0);
		write_reg(REG_IF_TARGET, if_tgt, 1'b1);
	endtask

	// nothing in flight before a register write
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_trims.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] near(input logic [31:0] center, input int unsigned spread);
		longint v;
		v = longint'(center) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
		if (v < 0)
			v = 0;
		if (v > COUNT_TOP)
			v = COUNT_TOP;
		return v[31:0];
	endfunction

	// mostly counts around the thresholds, some full-range noise
	function automatic counts_t random_counts();
		counts_t c;
		if ($urandom_range(0, 7) == 0) begin
			c = {$urandom, $urandom, $urandom, $urandom};
		end else begin
			c.hf = near(HF_NOMINAL, 5000);
			c.rc = near(RC_NOMINAL, 900);
			c.lc = near(lc_goal_r, 3);
			c.if_cnt = near(if_target_r, 2100);
		end
		return c;
	endfunction

	task automatic shuffle_idling();
		int unsigned pick;
		pick = $urandom_range(0, 2);
		idle_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
		pick = $urandom_range(0, 2);
		stall_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
	endtask

	task automatic send_random_block(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0)
				shuffle_idling();
			send_counts(random_counts());
		end
	endtask

	// first two events only count, codes hold their reset values
	task automatic test_early_events();
		send_counts(random_counts());
		send_counts(random_counts());
	endtask

	task automatic test_trim_edges();
		wait_idle();
		// zero total: the counter wraps through 255 before finishing
		write_reg(REG_EVENT_TOTAL, 32'd0, 1'b1);
		// everything at zero, lc at its top, if target under the band
		load_trim_plan(32'h0, 32'h0, 32'h0, 32'hFFFF, 32'hFFFF_FFFF, 32'd1399);
		send_counts(counts_t'{32'd0, 32'd0, 32'd0, 32'd0});
		send_counts(counts_t'{HF_SLOW, RC_SLOW_COARSE, 32'hFFFF_FFFF, 32'd2799});
		send_counts(counts_t'{HF_FAST + 1, RC_SLOW_FINE - 1, 32'd0, 32'd2800});

		// hf borrow, rc saturated high, if carry into coarse
		wait_idle();
		load_trim_plan(32'h060, 32'h7FFF, 32'h09F, 32'h0, 32'd100, 32'd5000);
		send_counts(counts_t'{HF_SLOW - 1, RC_FAST_COARSE + 1, 32'd101, 32'd6401});
		send_counts(counts_t'{HF_FAST, RC_FAST_FINE + 1, 32'd100, 32'd6400});
		send_counts(counts_t'{HF_SLOW - 1, RC_FAST_SUPER + 1, 32'd99, 32'd3599});
		send_counts(counts_t'{HF_SLOW, RC_FAST_SUPER, 32'd99, 32'd3600});
		send_counts(counts_t'{HF_SLOW - 1, RC_SLOW_SUPER - 1, 32'd100, 32'd0});
		send_counts(counts_t'{HF_NOMINAL, RC_SLOW_SUPER, 32'd100, 32'hFFFF_FFFF});

		// hf and if codes at the top, if target at its maximum
		wait_idle();
		load_trim_plan(32'h3FF, 32'h4000, 32'h3FF, 32'h1, 32'd0, IF_TARGET_MAX);
		send_counts(counts_t'{HF_FAST + 1, RC_SLOW_SUPER - 1, 32'd5, 32'hFFFF_FFFF});
		send_counts(counts_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
		send_counts(counts_t'{HF_FAST + 1, RC_SLOW_COARSE - 1, 32'd0, 32'hFFFF_FFFF});

		// hf and if carry below the coarse top, lc climbing to its top
		wait_idle();
		load_trim_plan(32'h3DF, 32'h03E0, 32'h3DF, 32'hFFFE, 32'd1000, IF_TARGET_RESET);
		send_counts(counts_t'{HF_FAST + 1, RC_FAST_FINE + 1, 32'd0, 32'd2801});
		send_counts(counts_t'{HF_FAST + 1, RC_FAST_FINE, 32'd0, 32'd0});
		send_counts(counts_t'{HF_SLOW - 1, RC_SLOW_FINE - 1, 32'd1000, 32'd1});
	endtask

	task automatic test_random_calibration();
		for (int unsigned p = 0; p < 7; p++) begin
			wait_idle();
			// total equal to the current count keeps calibration running a full wrap
			write_reg(REG_EVENT_TOTAL, {24'd0, evt_index}, 1'b0);
			case (p)
				0: load_trim_plan(32'h0, 32'h0, 32'h0, 32'h0, 32'd0, IF_TARGET_RESET);
				1: load_trim_plan(32'h3FF, 32'h7FFF, 32'h3FF, 32'hFFFF, 32'hFFFF_FFFF,
					IF_TARGET_MAX);
				default: load_trim_plan($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(IF_BAND, IF_TARGET_MAX));
			endcase
			send_random_block(130);
		end
	endtask

	task automatic test_finish();
		wait_idle();
		write_reg(REG_EVENT_TOTAL, 32'd255, 1'b1);
		shuffle_idling();
		while (!cal_done)
			send_counts(random_counts());
	endtask

	// after done every event returns the held codes, start writes still load
	task automatic test_hold_after_done();
		for (int unsigned b = 0; b < 4; b++) begin
			wait_idle();
			case (b)
				0: write_reg(REG_EVENT_TOTAL, 32'd1, 1'b1);
				1: begin
					write_reg(REG_HF_TRIM_START, $urandom, 1'b0);
					write_reg(REG_RC_TRIM_START, $urandom, 1'b1);
				end
				2: begin
					write_reg(REG_LC_CODE_START, $urandom, 1'b0);
					write_reg(REG_IF_TRIM_START, $urandom, 1'b1);
				end
				default: begin
					write_reg(REG_UNUSED, $urandom, 1'b0);
					write_reg(REG_LC_TARGET, $urandom, 1'b0);
					write_reg(REG_IF_TARGET, $urandom_range(IF_BAND, IF_TARGET_MAX), 1'b1);
				end
			endcase
			send_random_block(60);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		hf_count = 32'd0;
		rc_count = 32'd0;
		lc_count = 32'd0;
		if_count = 32'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LC_TARGET;
		cfg_data = 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_early_events();
		test_trim_edges();
		test_random_calibration();
		test_finish();
		test_hold_after_done();

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
rtl/otc_pkg.sv
rtl/otc_seq.sv
rtl/otc_correct.sv
rtl/oscillator_trim_calibrator.sv
sim/oscillator_trim_calibrator_test.sv
